// ===== hw/rtl/cmav_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmav_pkg
// Shared constants and types of the centered moving-average filter.
// ----------------------------------------------------------------------------
package cmav_pkg;

  localparam int MAX_HALF_WIN = 8;
  localparam int LINE_DEPTH   = 2 * MAX_HALF_WIN + 1;
  localparam int COUNT_CAP    = 2 * MAX_HALF_WIN + 2;

  localparam int WORD_W = 32;
  localparam int SUM_W  = 37;
  localparam int HALF_W = 4;
  localparam logic [HALF_W-1:0] HALF_RESET = 4'd5;

  localparam int IDX_W = $clog2(LINE_DEPTH);
  localparam int WIN_W = $clog2(LINE_DEPTH + 1);
  localparam int CNT_W = $clog2(COUNT_CAP + 1);
  localparam int CMP_W = (HALF_W > IDX_W) ? HALF_W : IDX_W;
  localparam int REM_W = $clog2(2 * LINE_DEPTH);
  localparam int STEP_W = $clog2(SUM_W + 1);

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One result to produce: a raw point or a window sum to divide.
  typedef struct packed {
    logic                    averaged;
    logic                    last;
    logic [WIN_W-1:0]        win;
    logic signed [SUM_W-1:0] val_x;
    logic signed [SUM_W-1:0] val_y;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

endpackage

// ===== hw/rtl/centered_moving_average_2d.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centered_moving_average_2d
// Centered moving average of a stream of signed Q16.16 2D points.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one point per transfer with
//   seq_last on the final point of a sequence. Output channel (out_valid /
//   out_stall) carries one result per transfer: the window mean or the raw
//   point, was_averaged, and out_last on the final result of a sequence.
//   The configuration channel (cfg_valid / cfg_ready) writes half_window;
//   a write also drops any unfinished sequence. Write it only while idle.
// Flow:
//   The front takes no new point while it issues the jobs of the last one
//   (none until more than min(half_window, 8) points are in, one for a later
//   point, and up to min(half_window, 8)+1 for the last point of a sequence).
//   A raw result passes through the job queue to the output register; an
//   averaged result also passes through the 37-step bit-serial divider,
//   and the back end takes no new job until that result is loaded.
//   A 4-entry job queue lets the front keep taking points meanwhile.
// Reset:
//   rst (synchronous) sets half_window to 5, clears the point count, sums
//   and queue. The delay line holds no reset value; unread entries are
//   gated by the point count. A stall on the output holds the result in
//   place; the back end then waits and the queue fills, stalling the input.
// ----------------------------------------------------------------------------
module centered_moving_average_2d (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [cmav_pkg::WORD_W-1:0] sample_x,
  input  logic signed [cmav_pkg::WORD_W-1:0] sample_y,
  input  logic                               seq_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cmav_pkg::HALF_W-1:0]        half_window,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [cmav_pkg::WORD_W-1:0] smooth_x,
  output logic signed [cmav_pkg::WORD_W-1:0] smooth_y,
  output logic                               was_averaged,
  output logic                               out_last
);

  cmav_pkg::push_t push;
  cmav_pkg::job_t  head;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;

  // Front: window bookkeeping, one job per result.
  cmav_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample_x    (sample_x),
    .sample_y    (sample_y),
    .seq_last    (seq_last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .half_window (half_window),
    .push        (push),
    .q_full      (q_full)
  );

  // Queue: decouple bookkeeping from the slow divider.
  cmav_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (head)
  );

  // Back: divide window sums, drive the output register.
  cmav_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_job        (head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .smooth_x     (smooth_x),
    .smooth_y     (smooth_y),
    .was_averaged (was_averaged),
    .out_last     (out_last)
  );

endmodule

// ===== hw/rtl/cmav_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmav_front
// Accepts points, keeps the delay line and running sums, and issues one
// job per result into the queue.
// ----------------------------------------------------------------------------
module cmav_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [cmav_pkg::WORD_W-1:0] sample_x,
  input  logic signed [cmav_pkg::WORD_W-1:0] sample_y,
  input  logic                              seq_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cmav_pkg::HALF_W-1:0]       half_window,
  output cmav_pkg::push_t                   push,
  input  logic                              q_full
);

  typedef enum logic {F_IDLE, F_EMIT} fstate_t;

  fstate_t state;
  logic [cmav_pkg::HALF_W-1:0] half_win;
  logic [cmav_pkg::WORD_W-1:0] line_x [cmav_pkg::LINE_DEPTH];
  logic [cmav_pkg::WORD_W-1:0] line_y [cmav_pkg::LINE_DEPTH];
  logic [cmav_pkg::CNT_W-1:0]  points_seen;
  logic signed [cmav_pkg::SUM_W-1:0] sum_x, sum_y;
  logic [cmav_pkg::IDX_W-1:0]  k;
  logic                        seq_end;

  logic [cmav_pkg::IDX_W-1:0]  eff_h;
  logic [cmav_pkg::WIN_W-1:0]  win;
  logic [cmav_pkg::CNT_W-1:0]  n_next;
  logic [cmav_pkg::CNT_W-1:0]  n_less;
  logic [cmav_pkg::IDX_W-1:0]  rd_idx;
  logic [cmav_pkg::IDX_W-1:0]  top;
  logic [cmav_pkg::WORD_W-1:0] rd_x, rd_y;
  logic signed [cmav_pkg::SUM_W-1:0] sum_x_next, sum_y_next;
  logic signed [cmav_pkg::SUM_W-1:0] new_x, new_y, old_x, old_y;
  logic                        drop;
  logic                        avg_now;
  logic                        accept;

  always_comb begin
    eff_h = (cmav_pkg::CMP_W'(half_win) > cmav_pkg::CMP_W'(cmav_pkg::MAX_HALF_WIN)) ?
            cmav_pkg::IDX_W'(cmav_pkg::MAX_HALF_WIN) : cmav_pkg::IDX_W'(half_win);
    win    = cmav_pkg::WIN_W'({eff_h, 1'b0}) + cmav_pkg::WIN_W'(1);
    n_next = (points_seen < cmav_pkg::CNT_W'(cmav_pkg::COUNT_CAP)) ?
             points_seen + cmav_pkg::CNT_W'(1) : cmav_pkg::CNT_W'(cmav_pkg::COUNT_CAP);
    n_less = n_next - cmav_pkg::CNT_W'(1);
    top    = (n_less < cmav_pkg::CNT_W'(eff_h)) ? cmav_pkg::IDX_W'(n_less) : eff_h;

    // Idle: tap the point leaving the window; emitting: tap the result point.
    rd_idx = (state == F_IDLE) ? cmav_pkg::IDX_W'({eff_h, 1'b0}) : k;
    rd_x   = line_x[rd_idx];
    rd_y   = line_y[rd_idx];

    new_x = {{(cmav_pkg::SUM_W-cmav_pkg::WORD_W){sample_x[cmav_pkg::WORD_W-1]}}, sample_x};
    new_y = {{(cmav_pkg::SUM_W-cmav_pkg::WORD_W){sample_y[cmav_pkg::WORD_W-1]}}, sample_y};
    old_x = {{(cmav_pkg::SUM_W-cmav_pkg::WORD_W){rd_x[cmav_pkg::WORD_W-1]}}, rd_x};
    old_y = {{(cmav_pkg::SUM_W-cmav_pkg::WORD_W){rd_y[cmav_pkg::WORD_W-1]}}, rd_y};

    drop = n_next > cmav_pkg::CNT_W'(win);
    sum_x_next = sum_x + new_x - (drop ? old_x : '0);
    sum_y_next = sum_y + new_y - (drop ? old_y : '0);

    avg_now = (k == eff_h) && (points_seen >= cmav_pkg::CNT_W'(win));

    push.valid        = (state == F_EMIT);
    push.job.averaged = avg_now;
    push.job.last     = seq_end && (k == '0);
    push.job.win      = win;
    push.job.val_x    = avg_now ? sum_x : old_x;
    push.job.val_y    = avg_now ? sum_y : old_y;

    cfg_ready = (state == F_IDLE);
    in_stall  = (state != F_IDLE) || cfg_valid;
    accept    = in_valid && !in_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      half_win    <= cmav_pkg::HALF_RESET;
      points_seen <= '0;
      sum_x       <= '0;
      sum_y       <= '0;
      k           <= '0;
      seq_end     <= 1'b0;
    end else begin
      case (state)
        F_IDLE: begin
          if (cfg_valid) begin
            half_win    <= half_window;
            points_seen <= '0;
            sum_x       <= '0;
            sum_y       <= '0;
          end else if (accept) begin
            sum_x       <= sum_x_next;
            sum_y       <= sum_y_next;
            points_seen <= n_next;
            seq_end     <= seq_last;
            for (int i = cmav_pkg::LINE_DEPTH - 1; i > 0; i--) begin
              line_x[i] <= line_x[i-1];
              line_y[i] <= line_y[i-1];
            end
            line_x[0] <= sample_x;
            line_y[0] <= sample_y;
            if (seq_last) begin
              k     <= top;
              state <= F_EMIT;
            end else if (n_next > cmav_pkg::CNT_W'(eff_h)) begin
              k     <= eff_h;
              state <= F_EMIT;
            end
          end
        end
        F_EMIT: begin
          if (!q_full) begin
            if (seq_end && (k != '0)) begin
              k <= k - cmav_pkg::IDX_W'(1);
            end else begin
              state <= F_IDLE;
              if (seq_end) begin
                points_seen <= '0;
                sum_x       <= '0;
                sum_y       <= '0;
              end
            end
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  a_last_flushes: assert property (@(posedge clk) disable iff (rst)
    accept && seq_last |=> state == F_EMIT)
    else $error("last point did not start a flush");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    points_seen <= cmav_pkg::CNT_W'(cmav_pkg::COUNT_CAP))
    else $error("point count beyond cap");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    state == F_EMIT && seq_end && k == '0 && !q_full |=> points_seen == '0)
    else $error("sequence state not cleared after flush");

endmodule

// ===== hw/rtl/cmav_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmav_queue
// Short job queue between the front and the divider back end.
// ----------------------------------------------------------------------------
module cmav_queue (
  input  logic            clk,
  input  logic            rst,
  input  cmav_pkg::push_t push,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output cmav_pkg::job_t  head
);

  cmav_pkg::job_t mem [cmav_pkg::Q_DEPTH];
  logic [cmav_pkg::Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [cmav_pkg::Q_CNT_W-1:0] count;
  logic do_push, do_pop;

  always_comb begin
    full       = (count == cmav_pkg::Q_CNT_W'(cmav_pkg::Q_DEPTH));
    head_valid = (count != '0);
    head       = mem[rd_ptr];
    do_push    = push.valid && !full;
    do_pop     = pop && head_valid;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == cmav_pkg::Q_PTR_W'(cmav_pkg::Q_DEPTH - 1)) ?
                  '0 : wr_ptr + cmav_pkg::Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == cmav_pkg::Q_PTR_W'(cmav_pkg::Q_DEPTH - 1)) ?
                  '0 : rd_ptr + cmav_pkg::Q_PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + cmav_pkg::Q_CNT_W'(1);
        2'b01:   count <= count - cmav_pkg::Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cmav_pkg::Q_CNT_W'(cmav_pkg::Q_DEPTH))
    else $error("queue count overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + cmav_pkg::Q_CNT_W'(1))
    else $error("queue count lost a push");

endmodule

// ===== hw/rtl/cmav_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmav_back
// Takes jobs from the queue, divides window sums by the window length one
// quotient bit per cycle, and holds each result in the output register.
// ----------------------------------------------------------------------------
module cmav_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  input  cmav_pkg::job_t                     q_job,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [cmav_pkg::WORD_W-1:0] smooth_x,
  output logic signed [cmav_pkg::WORD_W-1:0] smooth_y,
  output logic                               was_averaged,
  output logic                               out_last
);

  typedef enum logic [1:0] {B_IDLE, B_DIV, B_SEND} bstate_t;

  bstate_t state;
  logic [cmav_pkg::REM_W-1:0]  rem_x, rem_y;
  logic [cmav_pkg::SUM_W-1:0]  quo_x, quo_y;
  logic                        neg_x, neg_y;
  logic [cmav_pkg::WIN_W-1:0]  win;
  logic                        job_last;
  logic [cmav_pkg::STEP_W-1:0] step;

  logic out_free;
  logic load_out;
  logic [cmav_pkg::REM_W-1:0] sh_x, sh_y, rem_x_next, rem_y_next;
  logic ge_x, ge_y;
  logic [cmav_pkg::SUM_W-1:0] mag_x, mag_y, res_x, res_y;

  always_comb begin
    out_free = !out_valid || !out_stall;

    sh_x = {rem_x[cmav_pkg::REM_W-2:0], quo_x[cmav_pkg::SUM_W-1]};
    sh_y = {rem_y[cmav_pkg::REM_W-2:0], quo_y[cmav_pkg::SUM_W-1]};
    ge_x = sh_x >= cmav_pkg::REM_W'(win);
    ge_y = sh_y >= cmav_pkg::REM_W'(win);
    rem_x_next = ge_x ? sh_x - cmav_pkg::REM_W'(win) : sh_x;
    rem_y_next = ge_y ? sh_y - cmav_pkg::REM_W'(win) : sh_y;

    mag_x = q_job.val_x[cmav_pkg::SUM_W-1] ? '0 - q_job.val_x : q_job.val_x;
    mag_y = q_job.val_y[cmav_pkg::SUM_W-1] ? '0 - q_job.val_y : q_job.val_y;
    res_x = neg_x ? '0 - quo_x : quo_x;
    res_y = neg_y ? '0 - quo_y : quo_y;

    q_pop = (state == B_IDLE) && q_valid && (q_job.averaged || out_free);

    // Load the output register with a raw job or a finished quotient.
    load_out = out_free && (((state == B_IDLE) && q_valid && !q_job.averaged) ||
                            (state == B_SEND));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            if (q_job.averaged) begin
              rem_x    <= '0;
              rem_y    <= '0;
              quo_x    <= mag_x;
              quo_y    <= mag_y;
              neg_x    <= q_job.val_x[cmav_pkg::SUM_W-1];
              neg_y    <= q_job.val_y[cmav_pkg::SUM_W-1];
              win      <= q_job.win;
              job_last <= q_job.last;
              step     <= '0;
              state    <= B_DIV;
            end else if (out_free) begin
              smooth_x     <= q_job.val_x[cmav_pkg::WORD_W-1:0];
              smooth_y     <= q_job.val_y[cmav_pkg::WORD_W-1:0];
              was_averaged <= 1'b0;
              out_last     <= q_job.last;
            end
          end
        end
        B_DIV: begin
          rem_x <= rem_x_next;
          rem_y <= rem_y_next;
          quo_x <= {quo_x[cmav_pkg::SUM_W-2:0], ge_x};
          quo_y <= {quo_y[cmav_pkg::SUM_W-2:0], ge_y};
          step  <= step + cmav_pkg::STEP_W'(1);
          if (step == cmav_pkg::STEP_W'(cmav_pkg::SUM_W - 1)) begin
            state <= B_SEND;
          end
        end
        B_SEND: begin
          if (out_free) begin
            smooth_x     <= res_x[cmav_pkg::WORD_W-1:0];
            smooth_y     <= res_y[cmav_pkg::WORD_W-1:0];
            was_averaged <= 1'b1;
            out_last     <= job_last;
            state        <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == B_DIV |-> step < cmav_pkg::STEP_W'(cmav_pkg::SUM_W))
    else $error("divider ran past its last step");

  a_send_loads: assert property (@(posedge clk) disable iff (rst)
    state == B_SEND && out_free |=> out_valid && was_averaged)
    else $error("averaged result not loaded");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == B_IDLE)
    else $error("job taken while divider busy");

endmodule
